### rtl/tfcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcrc_pkg
// Types and constants shared by the text frame CRC-8 trailer checker.
// ----------------------------------------------------------------------------
package tfcrc_pkg;

  // CRC-8, MSB first, no reflection, no final XOR
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // Characters of interest in the frame text
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;  // first of TAB, LF, VT, FF, CR
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Parse phase of the field after the most recent comma
  typedef enum logic [2:0] {
    PH_PREFIX_C1 = 3'd0,  // first 'C' expected
    PH_PREFIX_R  = 3'd1,  // 'R' expected
    PH_PREFIX_C2 = 3'd2,  // second 'C' expected
    PH_LEADING   = 3'd3,  // skipping blanks, sign or digit expected
    PH_DIGITS    = 3'd4,  // collecting digits
    PH_ENDED     = 3'd5,  // value ended
    PH_FAILED    = 3'd6   // prefix mismatch, not a trailer
  } field_phase_e;

endpackage

### rtl/tfcrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcrc_if
// Valid/ready channels of the trailer checker: frame bytes in, results out.
// ----------------------------------------------------------------------------
interface tfcrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tfcrc_result_if;
  logic       valid;
  logic       ready;
  logic       crc_match;
  logic       trailer_found;
  logic [7:0] computed_crc;
  logic [7:0] trailer_crc;

  modport source (output valid, output crc_match, output trailer_found,
                  output computed_crc, output trailer_crc, input ready);
  modport sink   (input valid, input crc_match, input trailer_found,
                  input computed_crc, input trailer_crc, output ready);
endinterface

### rtl/text_frame_crc8_trailer_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_frame_crc8_trailer_check_unit
// Running CRC-8 (poly 0x07) over a text frame with a decimal "CRC" trailer
// parsed from the field after the last comma; one result per frame.
//
//   channel | dir | transaction
//   --------+-----+-------------------------------------------------------
//   in_i    | in  | one frame byte, last_byte marks the end of the frame
//   out_o   | out | crc_match, trailer_found, computed_crc, trailer_crc
//
// One byte per cycle while in_i is not stalled; each byte is folded into the
// frame state in the cycle it is accepted. The result is registered when the
// last byte is accepted. in_i stalls only while a result is held and out_o is
// not ready; a held result that leaves in the same cycle does not stall in_i.
// Reset clears the frame state and the output valid; state also returns to
// its reset values after every last byte.
// ----------------------------------------------------------------------------
module text_frame_crc8_trailer_check_unit
  import tfcrc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  tfcrc_byte_if.sink      in_i,
  tfcrc_result_if.source  out_o
);

  // Frame state
  logic [7:0]   running_crc_q, running_crc_d;
  logic [7:0]   crc_at_comma_q, crc_at_comma_d;
  logic         comma_seen_q, comma_seen_d;
  field_phase_e phase_q, phase_d;
  logic         minus_q, minus_d;
  logic [7:0]   acc_q, acc_d;

  // Output register
  logic         out_valid_q;
  logic         crc_match_q, crc_match_d;
  logic         trailer_q, trailer_d;
  logic [7:0]   computed_q, computed_d;
  logic [7:0]   received_q, received_d;

  logic         in_accept;
  logic [7:0]   b;
  logic         is_blank, is_digit;
  logic [7:0]   acc_digit;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;

  // Character classes and decimal step
  assign is_blank  = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign acc_digit = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + (b - CHAR_ZERO);

  // CRC-8 update, one bit per step
  always_comb begin
    logic [7:0] c;
    c = running_crc_q ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    running_crc_d = c;
  end

  // Next phase of the field parser
  always_comb begin
    phase_d = phase_q;
    if (b == CHAR_COMMA) begin
      phase_d = PH_PREFIX_C1;
    end else if (comma_seen_q) begin
      case (phase_q)
        PH_PREFIX_C1: phase_d = (b == CHAR_C) ? PH_PREFIX_R : PH_FAILED;
        PH_PREFIX_R:  phase_d = (b == CHAR_R) ? PH_PREFIX_C2 : PH_FAILED;
        PH_PREFIX_C2: phase_d = (b == CHAR_C) ? PH_LEADING : PH_FAILED;
        PH_LEADING: begin
          if (is_blank) phase_d = PH_LEADING;
          else if (b == CHAR_PLUS || b == CHAR_MINUS || is_digit) phase_d = PH_DIGITS;
          else phase_d = PH_ENDED;
        end
        PH_DIGITS:    phase_d = is_digit ? PH_DIGITS : PH_ENDED;
        default:      phase_d = phase_q;
      endcase
    end
  end

  // Data path of the parser: comma capture, sign and accumulator
  always_comb begin
    crc_at_comma_d = crc_at_comma_q;
    comma_seen_d   = comma_seen_q;
    minus_d        = minus_q;
    acc_d          = acc_q;
    if (b == CHAR_COMMA) begin
      crc_at_comma_d = running_crc_q;
      comma_seen_d   = 1'b1;
      minus_d        = 1'b0;
      acc_d          = '0;
    end else if (comma_seen_q) begin
      case (phase_q)
        PH_LEADING: begin
          if (!is_blank && b == CHAR_MINUS) minus_d = 1'b1;
          if (!is_blank && is_digit) acc_d = acc_digit;
        end
        PH_DIGITS: begin
          if (is_digit) acc_d = acc_digit;
        end
        default: acc_d = acc_q;
      endcase
    end
  end

  // Frame result from the state after this byte
  always_comb begin
    trailer_d  = comma_seen_d &&
                 (phase_d == PH_LEADING || phase_d == PH_DIGITS || phase_d == PH_ENDED);
    computed_d = comma_seen_d ? crc_at_comma_d : 8'h00;
    received_d = 8'h00;
    if (trailer_d) received_d = minus_d ? (8'h00 - acc_d) : acc_d;
    crc_match_d = trailer_d && (received_d == computed_d);
  end

  // Frame state registers; cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_crc_q  <= CRC_INIT;
      crc_at_comma_q <= 8'h00;
      comma_seen_q   <= 1'b0;
      phase_q        <= PH_PREFIX_C1;
      minus_q        <= 1'b0;
      acc_q          <= 8'h00;
    end else if (in_accept) begin
      if (in_i.last_byte) begin
        running_crc_q  <= CRC_INIT;
        crc_at_comma_q <= 8'h00;
        comma_seen_q   <= 1'b0;
        phase_q        <= PH_PREFIX_C1;
        minus_q        <= 1'b0;
        acc_q          <= 8'h00;
      end else begin
        running_crc_q  <= running_crc_d;
        crc_at_comma_q <= crc_at_comma_d;
        comma_seen_q   <= comma_seen_d;
        phase_q        <= phase_d;
        minus_q        <= minus_d;
        acc_q          <= acc_d;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && in_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_accept && in_i.last_byte) begin
      crc_match_q <= crc_match_d;
      trailer_q   <= trailer_d;
      computed_q  <= computed_d;
      received_q  <= received_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.crc_match     = crc_match_q;
  assign out_o.trailer_found = trailer_q;
  assign out_o.computed_crc  = computed_q;
  assign out_o.trailer_crc   = received_q;

`ifndef ASSERT_OFF
  a_match_needs_trailer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && crc_match_q |-> trailer_q)
    else $error("crc_match without trailer");

  a_no_trailer_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !trailer_q |-> received_q == 8'h00)
    else $error("trailer_crc nonzero without trailer");

  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_i.last_byte |=> out_valid_q)
    else $error("last byte gave no result");

  a_frame_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_i.last_byte |=> !comma_seen_q && phase_q == PH_PREFIX_C1 &&
    running_crc_q == CRC_INIT)
    else $error("frame state not cleared after last byte");

  a_phase_needs_comma : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_PREFIX_C1 |-> comma_seen_q)
    else $error("field parser advanced without a comma");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text frame CRC-8 trailer checker. Frames go in
// one byte per transaction with random gaps; results come back under random
// backpressure and are compared field by field against an in-bench model of
// the CRC and trailer parser. A short directed table comes first, then
// random frames: mostly well-formed trailers, plus noise and broken trailers.
// ----------------------------------------------------------------------------
module tb;
  import tfcrc_pkg::*;

  typedef struct packed {
    logic       crc_match;
    logic       trailer_found;
    logic [7:0] computed_crc;
    logic [7:0] trailer_crc;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    data_byte;
    logic          last_byte;
    logic          typed;
    frame_result_t typed_res;
  } stim_row_t;

  localparam frame_result_t RES_NONE  = '0;
  localparam frame_result_t RES_EMPTY = '{1'b1, 1'b1, 8'h00, 8'h00};
  localparam int RANDOM_BYTES = 400;

  // Directed frames: no comma, lone comma, bare trailer, failed prefix,
  // extreme bytes, blank plus sign plus wrapping number, blank after a sign
  localparam stim_row_t DIRECTED_TBL [25] = '{
    '{8'h41, 1'b1, 1'b1, RES_NONE},
    '{CHAR_COMMA, 1'b1, 1'b1, RES_NONE},
    '{CHAR_COMMA, 1'b0, 1'b0, RES_NONE},
    '{CHAR_C, 1'b0, 1'b0, RES_NONE},
    '{CHAR_R, 1'b0, 1'b0, RES_NONE},
    '{CHAR_C, 1'b1, 1'b1, RES_EMPTY},
    '{8'hFF, 1'b0, 1'b0, RES_NONE},
    '{CHAR_COMMA, 1'b0, 1'b0, RES_NONE},
    '{8'h58, 1'b1, 1'b0, RES_NONE},
    '{8'h00, 1'b0, 1'b0, RES_NONE},
    '{CHAR_COMMA, 1'b0, 1'b0, RES_NONE},
    '{CHAR_C, 1'b0, 1'b0, RES_NONE},
    '{CHAR_R, 1'b0, 1'b0, RES_NONE},
    '{CHAR_C, 1'b0, 1'b0, RES_NONE},
    '{CHAR_TAB, 1'b0, 1'b0, RES_NONE},
    '{CHAR_PLUS, 1'b0, 1'b0, RES_NONE},
    '{8'h33, 1'b0, 1'b0, RES_NONE},
    '{CHAR_ZERO, 1'b0, 1'b0, RES_NONE},
    '{CHAR_ZERO, 1'b1, 1'b0, RES_NONE},
    '{CHAR_COMMA, 1'b0, 1'b0, RES_NONE},
    '{CHAR_C, 1'b0, 1'b0, RES_NONE},
    '{CHAR_R, 1'b0, 1'b0, RES_NONE},
    '{CHAR_C, 1'b0, 1'b0, RES_NONE},
    '{CHAR_MINUS, 1'b0, 1'b0, RES_NONE},
    '{CHAR_SPACE, 1'b1, 1'b1, RES_EMPTY}
  };

  logic clk_i;
  logic rst_ni;

  tfcrc_byte_if   byte_ch ();
  tfcrc_result_if res_ch ();

  text_frame_crc8_trailer_check_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (res_ch)
  );

  // Model state of the frame parser
  logic [7:0]   frame_crc;
  logic [7:0]   comma_crc;
  logic         got_comma;
  field_phase_e phase;
  logic         neg;
  logic [7:0]   mag;

  frame_result_t expected_q[$];
  frame_result_t head;
  logic [7:0]    frame_q[$];
  int            errors;
  int            bytes_sent;
  logic          no_idle;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= CHAR_ZERO && b <= CHAR_NINE;
  endfunction

  function automatic void clear_frame();
    frame_crc = CRC_INIT;
    comma_crc = CRC_INIT;
    got_comma = 1'b0;
    phase     = PH_PREFIX_C1;
    neg       = 1'b0;
    mag       = 8'h00;
  endfunction

  // Fold one byte into the frame state; returns 1 with the result on the
  // last byte of a frame
  function automatic logic fold_byte(input logic [7:0] b, input logic last,
                                     output frame_result_t res);
    logic trailer;
    res = RES_NONE;
    if (b == CHAR_COMMA) begin
      comma_crc = frame_crc;
      got_comma = 1'b1;
      phase     = PH_PREFIX_C1;
      neg       = 1'b0;
      mag       = 8'h00;
    end else if (got_comma) begin
      case (phase)
        PH_PREFIX_C1: phase = (b == CHAR_C) ? PH_PREFIX_R : PH_FAILED;
        PH_PREFIX_R:  phase = (b == CHAR_R) ? PH_PREFIX_C2 : PH_FAILED;
        PH_PREFIX_C2: phase = (b == CHAR_C) ? PH_LEADING : PH_FAILED;
        PH_LEADING: begin
          if (is_blank(b)) begin
            phase = PH_LEADING;
          end else if (b == CHAR_PLUS) begin
            phase = PH_DIGITS;
          end else if (b == CHAR_MINUS) begin
            neg   = 1'b1;
            phase = PH_DIGITS;
          end else if (is_digit(b)) begin
            mag   = mag * 8'd10 + (b - CHAR_ZERO);
            phase = PH_DIGITS;
          end else begin
            phase = PH_ENDED;
          end
        end
        PH_DIGITS: begin
          if (is_digit(b)) mag = mag * 8'd10 + (b - CHAR_ZERO);
          else phase = PH_ENDED;
        end
        default: phase = phase;
      endcase
    end
    frame_crc = crc8_next(frame_crc, b);

    if (!last) return 1'b0;

    trailer = got_comma && (phase inside {PH_LEADING, PH_DIGITS, PH_ENDED});
    res.trailer_found = trailer;
    res.computed_crc  = got_comma ? comma_crc : 8'h00;
    res.trailer_crc   = trailer ? (neg ? 8'h00 - mag : mag) : 8'h00;
    res.crc_match     = trailer && (res.trailer_crc == res.computed_crc);
    clear_frame();
    return 1'b1;
  endfunction

  // Drive one byte after a random gap and wait for its transaction
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input frame_result_t typed_res);
    int            gap;
    frame_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    do @(posedge clk_i); while (!byte_ch.ready);
    if (fold_byte(b, last, res)) expected_q.push_back(typed ? typed_res : res);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CHAR_SPACE : CHAR_TAB + 8'(r);
  endfunction

  task automatic push_decimal(input int n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  task automatic push_noise(input int len, input int comma_odds);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, comma_odds) == 0) frame_q.push_back(CHAR_COMMA);
      else frame_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Build one random frame into frame_q
  task automatic build_frame();
    int         kind;
    int         sign;
    int         mag_val;
    int         keep;
    logic [7:0] body_crc;
    logic [7:0] b;
    logic [7:0] target;
    frame_q.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      // well-formed trailer, value often equal to the real CRC
      body_crc = CRC_INIT;
      repeat ($urandom_range(0, 10)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_COMMA && $urandom_range(0, 3) != 0) b = 8'h41;
        frame_q.push_back(b);
        body_crc = crc8_next(body_crc, b);
      end
      frame_q.push_back(CHAR_COMMA);
      frame_q.push_back(CHAR_C);
      frame_q.push_back(CHAR_R);
      frame_q.push_back(CHAR_C);
      repeat ($urandom_range(0, 2)) frame_q.push_back(pick_blank());
      target = $urandom_range(0, 1) ? body_crc : 8'($urandom_range(0, 255));
      sign   = $urandom_range(0, 3);
      if (sign == 2) frame_q.push_back(CHAR_PLUS);
      if (sign == 3) frame_q.push_back(CHAR_MINUS);
      mag_val = (sign == 3) ? (256 - int'(target)) % 256 : int'(target);
      if ($urandom_range(0, 4) == 0) mag_val += 256 * $urandom_range(1, 400);
      if ($urandom_range(0, 9) != 0) push_decimal(mag_val);
      push_noise($urandom_range(0, 2), 6);
    end else if (kind <= 8) begin
      push_noise($urandom_range(1, 16), 4);
    end else begin
      // broken trailer: mangled or cut prefix, or a blank after the sign
      push_noise($urandom_range(0, 6), 5);
      frame_q.push_back(CHAR_COMMA);
      if ($urandom_range(0, 1) == 0) begin
        keep = $urandom_range(0, 2);
        if (keep > 0) frame_q.push_back(CHAR_C);
        if (keep > 1) frame_q.push_back(CHAR_R);
        frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        frame_q.push_back(CHAR_C);
        frame_q.push_back(CHAR_R);
        frame_q.push_back(CHAR_C);
        frame_q.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
        frame_q.push_back(pick_blank());
      end
      push_decimal($urandom_range(0, 999));
    end
  endtask

  // Result channel: random stall before each transaction
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        head = expected_q.pop_front();
        if (res_ch.crc_match !== head.crc_match) begin
          $error("crc_match: expected %0d, actual %0d", head.crc_match, res_ch.crc_match);
          errors++;
        end
        if (res_ch.trailer_found !== head.trailer_found) begin
          $error("trailer_found: expected %0d, actual %0d",
                 head.trailer_found, res_ch.trailer_found);
          errors++;
        end
        if (res_ch.computed_crc !== head.computed_crc) begin
          $error("computed_crc: expected %0h, actual %0h",
                 head.computed_crc, res_ch.computed_crc);
          errors++;
        end
        if (res_ch.trailer_crc !== head.trailer_crc) begin
          $error("trailer_crc: expected %0h, actual %0h",
                 head.trailer_crc, res_ch.trailer_crc);
          errors++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int wait_cycles;
    errors     = 0;
    bytes_sent = 0;
    no_idle    = 1'b0;
    clear_frame();
    rst_ni            <= 1'b0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    byte_ch.last_byte <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_TBL[i]) begin
      send_byte(DIRECTED_TBL[i].data_byte, DIRECTED_TBL[i].last_byte,
                DIRECTED_TBL[i].typed, DIRECTED_TBL[i].typed_res);
    end

    while (bytes_sent < $size(DIRECTED_TBL) + RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 7) == 0);
      build_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, RES_NONE);
    end
    byte_ch.valid <= 1'b0;
    no_idle = 1'b0;

    // Drain outstanding results
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      errors++;
    end
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### text_frame_crc8_trailer_check_unit.f
rtl/tfcrc_pkg.sv
rtl/tfcrc_if.sv
rtl/text_frame_crc8_trailer_check_unit.sv
bench/tb.sv
